// File: rtl/rieasm_pkg.sv
// Shared types, codes and format tables for the RIE operand text assembler.
package rieasm_pkg;

	localparam int unsigned WORD_W  = 48;
	localparam int unsigned VALUE_W = 16;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HEX     = 3'd1;
	localparam logic [2:0] ST_LEN     = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_EXTRA   = 3'd4;

	localparam logic [2:0] FMT_A      = 3'd0;
	localparam logic [2:0] FMT_B      = 3'd1;
	localparam logic [2:0] FMT_C      = 3'd2;
	localparam logic [2:0] FMT_D      = 3'd3;
	localparam logic [2:0] FMT_E      = 3'd4;
	localparam logic [2:0] FMT_F      = 3'd5;
	localparam logic [2:0] FMT_G      = 3'd6;
	localparam logic [2:0] FMT_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0]  text_char;
		logic        end_of_text;
		logic [2:0]  format_select;
		logic [15:0] opcode_value;
	} rieasm_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] instruction_word;
		logic [2:0]        status;
	} rieasm_out_t;

	// number of operand fields of a sub-format
	function automatic logic [2:0] fmt_len(input logic [2:0] fmt);
		logic [2:0] len;
		unique case (fmt)
			FMT_A, FMT_D, FMT_E, FMT_G: len = 3'd3;
			FMT_B, FMT_C:               len = 3'd4;
			FMT_F:                      len = 3'd5;
			default:                    len = 3'd0;
		endcase
		return len;
	endfunction

	// digit limit of a field
	function automatic logic [2:0] field_digits(input logic [2:0] fmt, input logic [3:0] phase);
		logic [2:0] d;
		d = 3'd1;
		unique case (fmt)
			FMT_A, FMT_G: if (phase == 4'd1) d = 3'd4;
			FMT_B:        if (phase == 4'd3) d = 3'd4;
			FMT_C: begin
				if (phase == 4'd1) d = 3'd2;
				if (phase == 4'd3) d = 3'd4;
			end
			FMT_D, FMT_E: if (phase == 4'd2) d = 3'd4;
			FMT_F:        if (phase >= 4'd2) d = 3'd2;
			default:      d = 3'd0;
		endcase
		return d;
	endfunction

	// bit position of a field in the instruction word
	function automatic logic [5:0] field_shift(input logic [2:0] fmt, input logic [3:0] phase);
		logic [5:0] s;
		s = 6'd0;
		unique case (phase)
			4'd0: s = 6'd36;
			4'd1: begin
				if (fmt == FMT_A || fmt == FMT_G) s = 6'd16;
				else if (fmt == FMT_C)            s = 6'd8;
				else                              s = 6'd32;
			end
			4'd2: begin
				if (fmt == FMT_A || fmt == FMT_B)      s = 6'd12;
				else if (fmt == FMT_C || fmt == FMT_G) s = 6'd32;
				else if (fmt == FMT_F)                 s = 6'd24;
				else                                   s = 6'd16;
			end
			4'd3: s = 6'd16;
			4'd4: s = 6'd8;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	// {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

endpackage

// File: rtl/rie_operand_text_assembler_unit.sv
// Top level of the RIE operand text assembler: input register, field logic, result register.
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one operand character per word,
//   with the sub-format and opcode alongside. A word with end_of_text set closes the
//   instruction and produces exactly one result word on the output channel
//   (out_valid/out_ready/out_data): the packed 48-bit instruction and a status code.
//   Character words produce no result.
//   Throughput: one input word per cycle. A character is decoded, checked and folded into
//   the field state from the input register; the field and word registers feed back only
//   into themselves, so back-to-back words need no bubbles.
//   Path: an accepted end word is held in the input register, then its result is held in
//   the result register.
//   Stall: when out_ready is low the result register holds. Character words keep flowing;
//   an end word waits in the input register until the result register frees, and in_ready
//   drops behind it.
//   Reset: arst_n clears both pipeline valids, the error latch and all field state.
//   After each end word the field state returns to its reset value.
module rie_operand_text_assembler_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  rieasm_pkg::rieasm_in_t   in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output rieasm_pkg::rieasm_out_t  out_data
);
	import rieasm_pkg::*;

	rieasm_in_t        in_s1;
	logic              valid_s1;

	logic [3:0]        phase_q;
	logic [2:0]        count_q;
	logic [15:0]       value_q;
	logic              bad_q;
	logic [2:0]        err_q;
	logic [WORD_W-1:0] word_q;

	logic              out_valid_q;
	rieasm_out_t       out_data_q;

	logic              out_free;
	logic              s1_go;
	logic              step;

	logic [2:0]        len;
	logic [2:0]        digits;
	logic [5:0]        shift;
	logic [15:0]       mask;
	logic [4:0]        hex;
	logic              phase_done;
	logic [WORD_W-1:0] field_bits;
	logic [WORD_W-1:0] placed_word;

	logic [3:0]        n_phase;
	logic [2:0]        n_count;
	logic [15:0]       n_value;
	logic              n_bad;
	logic [2:0]        n_err;
	logic [WORD_W-1:0] n_word;
	logic [2:0]        end_status;
	logic [WORD_W-1:0] end_word;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = !in_s1.end_of_text || out_free;
	assign step     = valid_s1 && s1_go;
	assign in_ready = !valid_s1 || s1_go;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		len        = fmt_len(in_s1.format_select);
		digits     = field_digits(in_s1.format_select, phase_q);
		shift      = field_shift(in_s1.format_select, phase_q);
		hex        = hex_decode(in_s1.text_char);
		phase_done = (phase_q >= {1'b0, len});
		unique case (digits)
			3'd1:    mask = 16'h000F;
			3'd2:    mask = 16'h00FF;
			3'd3:    mask = 16'h0FFF;
			3'd4:    mask = 16'hFFFF;
			default: mask = 16'h0000;
		endcase
		field_bits  = WORD_W'(value_q & mask) << shift;
		placed_word = word_q | field_bits;
	end

	// next field state for a character word
	always_comb begin
		n_phase = phase_q;
		n_count = count_q;
		n_value = value_q;
		n_bad   = bad_q;
		n_err   = err_q;
		n_word  = word_q;
		if (err_q != ST_OK) begin
			n_err = err_q;
		end else if (in_s1.format_select == FMT_UNUSED) begin
			n_err = ST_MISSING;
		end else if (phase_done) begin
			n_err = ST_EXTRA;
		end else if (in_s1.text_char == CHAR_COMMA) begin
			if (count_q == 3'd0) begin
				n_err = ST_MISSING;
			end else if (bad_q) begin
				n_err = ST_HEX;
			end else begin
				n_word  = placed_word;
				n_phase = phase_q + 4'd1;
				n_count = 3'd0;
				n_value = 16'd0;
				n_bad   = 1'b0;
				if ((phase_q + 4'd1) >= {1'b0, len}) n_err = ST_EXTRA;
			end
		end else if (count_q >= digits) begin
			n_err = ST_LEN;
		end else begin
			n_count = count_q + 3'd1;
			if (!hex[4]) n_bad = 1'b1;
			else         n_value = {value_q[11:0], hex[3:0]};
		end
	end

	// result for an end word
	always_comb begin
		end_status = err_q;
		end_word   = word_q;
		if (err_q == ST_OK) begin
			if (in_s1.format_select == FMT_UNUSED) begin
				end_status = ST_MISSING;
			end else if (phase_done) begin
				end_status = ST_OK;
			end else if ((phase_q + 4'd1) == {1'b0, len}) begin
				if (count_q == 3'd0)  end_status = ST_MISSING;
				else if (bad_q)       end_status = ST_HEX;
				else                  end_word   = placed_word;
			end else begin
				end_status = ST_MISSING;
			end
		end
		if (end_status == ST_OK)
			end_word = end_word | {in_s1.opcode_value[15:8], 32'd0, in_s1.opcode_value[7:0]};
		else
			end_word = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) in_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
			value_q <= '0;
			bad_q   <= 1'b0;
			err_q   <= ST_OK;
			word_q  <= '0;
		end else if (step) begin
			if (in_s1.end_of_text) begin
				phase_q <= '0;
				count_q <= '0;
				value_q <= '0;
				bad_q   <= 1'b0;
				err_q   <= ST_OK;
				word_q  <= '0;
			end else begin
				phase_q <= n_phase;
				count_q <= n_count;
				value_q <= n_value;
				bad_q   <= n_bad;
				err_q   <= n_err;
				word_q  <= n_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && in_s1.end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk) begin
		if (step && in_s1.end_of_text) begin
			out_data_q.instruction_word <= end_word;
			out_data_q.status           <= end_status;
		end
	end

endmodule

// File: rtl/rieasm_checker.sv
// Port-level checks for the RIE operand text assembler, bound to the top level.
module rieasm_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input rieasm_pkg::rieasm_in_t   in_data,
	input logic                     out_valid,
	input logic                     out_ready,
	input rieasm_pkg::rieasm_out_t  out_data
);
	import rieasm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.instruction_word == '0)
		else $error("error result carries a nonzero instruction word");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_HEX ||
			out_data.status == ST_LEN || out_data.status == ST_MISSING ||
			out_data.status == ST_EXTRA))
		else $error("status code out of range");

	// a free result side never holds off the input
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the result side is ready");

endmodule

bind rie_operand_text_assembler_unit rieasm_checker u_rieasm_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the RIE operand text assembler unit.
module testbench;
	import rieasm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1500;
	localparam int LONG_HOLD    = 400;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DIR_N        = 22;

	typedef struct packed {
		logic [127:0] text;
		logic [2:0]   fmt;
		logic [2:0]   end_fmt;
		logic [15:0]  opcode;
		logic         pinned;
		rieasm_out_t  res;
	} dir_row_t;

	// text is right-justified, leading zero bytes are skipped
	localparam dir_row_t DIR_TABLE [DIR_N] = '{
		'{"f,FFFF,f",     FMT_A, FMT_A, 16'hFFFF, 1'b1, '{48'hFFF0_FFFF_F0FF, ST_OK}},
		'{"0,0,0",        FMT_A, FMT_A, 16'h0000, 1'b1, '{48'd0, ST_OK}},
		'{"1,2,3,4567",   FMT_B, FMT_B, 16'hE876, 1'b0, '{48'd0, ST_OK}},
		'{"a,bC,d,1234",  FMT_C, FMT_C, 16'hEC7C, 1'b0, '{48'd0, ST_OK}},
		'{"1,3,8000",     FMT_D, FMT_D, 16'hEC44, 1'b0, '{48'd0, ST_OK}},
		'{"2,4,7fff",     FMT_E, FMT_E, 16'hEC45, 1'b0, '{48'd0, ST_OK}},
		'{"1,2,34,56,78", FMT_F, FMT_F, 16'hEC55, 1'b0, '{48'd0, ST_OK}},
		'{"9,abcd,e",     FMT_G, FMT_G, 16'hEC42, 1'b0, '{48'd0, ST_OK}},
		'{"1,12G4,2",     FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_HEX}},
		'{"12,3,4",       FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_LEN}},
		'{"1,,2",         FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_MISSING}},
		'{"1,2",          FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_MISSING}},
		'{"1,2,",         FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_MISSING}},
		'{"1,2,3,",       FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_EXTRA}},
		'{"1,2,x",        FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_HEX}},
		'{"x1,2,3",       FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_LEN}},
		'{"1,2,34",       FMT_F, FMT_A, 16'h1234, 1'b0, '{48'd0, ST_OK}},
		'{"1,2,34,",      FMT_F, FMT_A, 16'h5678, 1'b0, '{48'd0, ST_OK}},
		'{"1",            FMT_UNUSED, FMT_UNUSED, 16'hEC70, 1'b1, '{48'd0, ST_MISSING}},
		'{"",             FMT_UNUSED, FMT_UNUSED, 16'hEC70, 1'b1, '{48'd0, ST_MISSING}},
		'{"",             FMT_A, FMT_A, 16'hEC70, 1'b1, '{48'd0, ST_MISSING}},
		'{"1,2,345",      FMT_F, FMT_F, 16'hEC70, 1'b1, '{48'd0, ST_LEN}}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	rieasm_in_t  in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rieasm_out_t out_data;

	// predictor state
	logic [3:0]  asm_phase = '0;
	logic [2:0]  asm_ndig  = '0;
	logic [15:0] asm_val   = '0;
	logic        asm_bad   = 1'b0;
	logic [2:0]  asm_err   = ST_OK;
	logic [47:0] asm_word  = '0;

	rieasm_out_t expected_insns [$];
	int          mismatches   = 0;
	int          words_in     = 0;
	int          insns_sent   = 0;
	int          insns_seen   = 0;
	int          burst_left   = 0;
	bit          hold_outputs = 1'b0;

	rie_operand_text_assembler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// field count, digit limits and bit positions of a sub-format, index 0 is the first field
	function automatic void fmt_layout(input logic [2:0] fmt, output int cnt,
			output logic [4:0][2:0] dg, output logic [4:0][5:0] sh);
		case (fmt)
			FMT_A: begin
				cnt = 3; dg = {3'd0, 3'd0, 3'd1, 3'd4, 3'd1};
				sh = {6'd0, 6'd0, 6'd12, 6'd16, 6'd36};
			end
			FMT_B: begin
				cnt = 4; dg = {3'd0, 3'd4, 3'd1, 3'd1, 3'd1};
				sh = {6'd0, 6'd16, 6'd12, 6'd32, 6'd36};
			end
			FMT_C: begin
				cnt = 4; dg = {3'd0, 3'd4, 3'd1, 3'd2, 3'd1};
				sh = {6'd0, 6'd16, 6'd32, 6'd8, 6'd36};
			end
			FMT_D, FMT_E: begin
				cnt = 3; dg = {3'd0, 3'd0, 3'd4, 3'd1, 3'd1};
				sh = {6'd0, 6'd0, 6'd16, 6'd32, 6'd36};
			end
			FMT_F: begin
				cnt = 5; dg = {3'd2, 3'd2, 3'd2, 3'd1, 3'd1};
				sh = {6'd8, 6'd16, 6'd24, 6'd32, 6'd36};
			end
			FMT_G: begin
				cnt = 3; dg = {3'd0, 3'd0, 3'd1, 3'd4, 3'd1};
				sh = {6'd0, 6'd0, 6'd32, 6'd16, 6'd36};
			end
			default: begin
				cnt = 0; dg = '0; sh = '0;
			end
		endcase
	endfunction

	function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] nib);
		nib = '0;
		if (c >= "0" && c <= "9") begin
			nib = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			nib = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			nib = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void place_field(input logic [2:0] digits, input logic [5:0] shift);
		logic [47:0] fld;
		fld = 48'(asm_val) & ((48'd1 << (4 * digits)) - 48'd1);
		asm_word  = asm_word | (fld << shift);
		asm_phase = asm_phase + 4'd1;
		asm_ndig  = '0;
		asm_val   = '0;
		asm_bad   = 1'b0;
	endfunction

	// advance the assembler state by one word; returns 1 with the instruction on an end word
	function automatic bit assemble_step(input rieasm_in_t w, output rieasm_out_t res);
		int              cnt;
		logic [4:0][2:0] dg;
		logic [4:0][5:0] sh;
		logic [3:0]      nib;
		logic [2:0]      st;
		res = '0;
		fmt_layout(w.format_select, cnt, dg, sh);
		if (!w.end_of_text) begin
			if (asm_err != ST_OK)
				return 1'b0;
			if (w.format_select == FMT_UNUSED)
				asm_err = ST_MISSING;
			else if (asm_phase >= cnt)
				asm_err = ST_EXTRA;
			else if (w.text_char == CHAR_COMMA) begin
				if (asm_ndig == 0)
					asm_err = ST_MISSING;
				else if (asm_bad)
					asm_err = ST_HEX;
				else begin
					place_field(dg[asm_phase], sh[asm_phase]);
					if (asm_phase >= cnt)
						asm_err = ST_EXTRA;
				end
			end else if (asm_ndig >= dg[asm_phase])
				asm_err = ST_LEN;
			else begin
				asm_ndig++;
				if (decode_hex(w.text_char, nib))
					asm_val = {asm_val[11:0], nib};
				else
					asm_bad = 1'b1;
			end
			return 1'b0;
		end
		st = asm_err;
		if (st == ST_OK) begin
			if (w.format_select == FMT_UNUSED || asm_phase + 1 < cnt)
				st = ST_MISSING;
			else if (asm_phase + 1 == cnt) begin
				if (asm_ndig == 0)
					st = ST_MISSING;
				else if (asm_bad)
					st = ST_HEX;
				else
					place_field(dg[asm_phase], sh[asm_phase]);
			end
		end
		res.status = st;
		if (st == ST_OK)
			res.instruction_word = asm_word |
				{w.opcode_value[15:8], 32'd0, w.opcode_value[7:0]};
		asm_phase = '0;
		asm_ndig  = '0;
		asm_val   = '0;
		asm_bad   = 1'b0;
		asm_err   = ST_OK;
		asm_word  = '0;
		return 1'b1;
	endfunction

	// offer one word, predict on acceptance, then idle at the end of a burst
	task automatic put_word(input rieasm_in_t w, input bit pinned, input rieasm_out_t pinned_res);
		rieasm_out_t res;
		in_data  <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_in++;
		if (assemble_step(w, res)) begin
			expected_insns.push_back(pinned ? pinned_res : res);
			insns_sent++;
		end
		if (burst_left > 0)
			burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
				: $urandom_range(0, 15);
		end
	endtask

	task automatic put_char(input logic [7:0] c, input logic [2:0] fmt);
		rieasm_in_t w;
		w.text_char     = c;
		w.end_of_text   = 1'b0;
		w.format_select = fmt;
		w.opcode_value  = 16'($urandom);
		put_word(w, 1'b0, '0);
	endtask

	task automatic put_end(input logic [2:0] fmt, input logic [15:0] op, input bit pinned,
			input rieasm_out_t pinned_res);
		rieasm_in_t w;
		w.text_char     = 8'($urandom);
		w.end_of_text   = 1'b1;
		w.format_select = fmt;
		w.opcode_value  = op;
		put_word(w, pinned, pinned_res);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'("0") + 8'(n);
		return (($urandom_range(0, 1) == 0) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		logic [3:0] nib;
		do
			c = 8'($urandom);
		while (decode_hex(c, nib) || c == CHAR_COMMA);
		return c;
	endfunction

	// mostly well-formed operand text with random digits; a quarter carries one flaw
	task automatic send_random_insn();
		logic [2:0]      fmt;
		logic [2:0]      cur_fmt;
		int              cnt;
		logic [4:0][2:0] dg;
		logic [4:0][5:0] sh;
		int              nfields;
		int              nd;
		int              flaw;
		int              bad_field;
		fmt = ($urandom_range(0, 39) == 0) ? FMT_UNUSED : 3'($urandom_range(0, 6));
		cur_fmt = fmt;
		fmt_layout(fmt, cnt, dg, sh);
		flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		nfields = (fmt == FMT_UNUSED) ? $urandom_range(0, 3) : cnt;
		bad_field = (nfields > 0) ? $urandom_range(0, nfields - 1) : 0;
		if (flaw == 1 && nfields > 0)
			nfields = $urandom_range(0, nfields - 1);
		for (int f = 0; f < nfields; f++) begin
			if (flaw == 7 && $urandom_range(0, 2) == 0)
				cur_fmt = 3'($urandom_range(0, 7));
			nd = (fmt == FMT_UNUSED) ? 1 : $urandom_range(1, dg[f]);
			if (f == bad_field && flaw == 2)
				nd = 0;
			if (f == bad_field && flaw == 3)
				nd++;
			for (int d = 0; d < nd; d++) begin
				if (f == bad_field && flaw == 4 && d == nd - 1)
					put_char(junk_char(), cur_fmt);
				else
					put_char(hex_char(4'($urandom)), cur_fmt);
			end
			if (f != nfields - 1)
				put_char(CHAR_COMMA, cur_fmt);
		end
		if (flaw == 5) begin
			put_char(CHAR_COMMA, cur_fmt);
			repeat ($urandom_range(0, 3))
				put_char(hex_char(4'($urandom)), cur_fmt);
		end
		if (flaw == 6) begin
			repeat ($urandom_range(1, 6))
				put_char(8'($urandom), cur_fmt);
		end
		put_end(cur_fmt, 16'($urandom), 1'b0, '0);
	endtask

	// hold the input until the block has handed back every instruction
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_insns.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		rieasm_out_t want;
		if (arst_n && out_valid && out_ready) begin
			insns_seen++;
			if (expected_insns.size() == 0)
				note_mismatch($sformatf("unexpected result word %h status %0d",
					out_data.instruction_word, out_data.status));
			else begin
				want = expected_insns.pop_front();
				if (out_data.instruction_word !== want.instruction_word)
					note_mismatch($sformatf("result %0d: instruction_word %h, expected %h",
						insns_seen, out_data.instruction_word, want.instruction_word));
				if (out_data.status !== want.status)
					note_mismatch($sformatf("result %0d: status %0d, expected %0d",
						insns_seen, out_data.status, want.status));
			end
		end
	end

	// receiver: rotating ready patterns, plus one long hold per request
	initial begin : rx_pacer
		int          left;
		logic [15:0] pat;
		left = 0;
		pat  = '1;
		@(posedge clk);
		forever begin
			if (hold_outputs) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD)
					@(posedge clk);
				hold_outputs = 1'b0;
			end else begin
				if (left == 0) begin
					left = $urandom_range(16, 96);
					case ($urandom_range(0, 3))
						0: pat = '1;
						1: pat = 16'($urandom);
						2: pat = 16'($urandom) | 16'($urandom);
						default: pat = 16'($urandom) & 16'($urandom);
					endcase
				end
				out_ready <= pat[0];
				pat = {pat[0], pat[15:1]};
				left--;
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TIMEOUT: no word moved for %0d cycles", QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int         start_words;
		int         k;
		logic [7:0] c;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			for (int i = 15; i >= 0; i--) begin
				c = DIR_TABLE[r].text[i*8 +: 8];
				if (c != 8'h00)
					put_char(c, DIR_TABLE[r].fmt);
			end
			put_end(DIR_TABLE[r].end_fmt, DIR_TABLE[r].opcode, DIR_TABLE[r].pinned,
				DIR_TABLE[r].res);
		end
		drain_results();

		start_words = words_in;
		k = 0;
		while (words_in - start_words < RANDOM_WORDS) begin
			// stall the receiver while random instructions keep coming, so the input backs up
			if (k == 0 || k == 90)
				hold_outputs = 1'b1;
			send_random_insn();
			if (k % 37 == 36)
				drain_results();
			k++;
		end

		drain_results();
		repeat (8)
			@(posedge clk);
		$display("Summary: %0d words driven, %0d instructions assembled and checked",
			words_in, insns_sent);
		$display("Summary: sub-formats a-g and the unused code, all status codes, mid-text format switches");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
rtl/rieasm_pkg.sv
rtl/rie_operand_text_assembler_unit.sv
rtl/rieasm_checker.sv
tb/sv/testbench.sv
